### design/dmoc_pkg.sv
// types and constants shared by the operation cache modules
// no dependencies

package dmoc_pkg;

  localparam int unsigned HandleW    = 64;
  localparam int unsigned HalfW      = 32;
  localparam int unsigned SlotW      = 12;
  localparam int unsigned TableSizeW = 13;
  localparam int unsigned OpW        = 3;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned DivSteps   = HalfW / DigitW;
  localparam int unsigned DivCntW    = $clog2(DivSteps);

  localparam logic [TableSizeW-1:0] TableSizeRst = 13'd4096;
  localparam logic                  TwoOperandRst = 1'b1;

  typedef enum logic [OpW-1:0] {
    OP_LOOKUP1 = 3'd0,
    OP_LOOKUP2 = 3'd1,
    OP_INSERT1 = 3'd2,
    OP_INSERT2 = 3'd3,
    OP_CLEAR   = 3'd4
  } op_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_TABLE_SIZE  = 2'd0,
    CFG_TWO_OPERAND = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CMP,
    ST_INSERT,
    ST_EMPTY,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]     operation;
    logic [HandleW-1:0] first_operand;
    logic [HandleW-1:0] second_operand;
    logic [SlotW-1:0]   slot;
    logic [HandleW-1:0] stored_value;
  } item_t;

  typedef struct packed {
    logic               found;
    logic [HandleW-1:0] found_value;
    logic [SlotW-1:0]   miss_slot;
    logic               miss_slot_valid;
  } result_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic mem_read;
    logic emit_lookup;
    logic emit_insert;
    logic emit_zero;
    logic clear_wr;
  } cmd_t;

  typedef struct packed {
    logic key_zero;
    logic clear_last;
  } status_t;

endpackage

### design/dmoc_rem.sv
// remainder unit: 32-bit dividend modulo a 13-bit divisor, four bits per step
// depends on dmoc_pkg

module dmoc_rem (
  input  logic                                 clk_i,
  input  logic                                 load_i,
  input  logic                                 step_i,
  input  logic [dmoc_pkg::HalfW-1:0]           dividend_i,
  input  logic [dmoc_pkg::TableSizeW-1:0]      divisor_i,
  output logic [dmoc_pkg::TableSizeW-1:0]      rem_o
);

  logic [dmoc_pkg::HalfW-1:0]      num_q, num_d;
  logic [dmoc_pkg::TableSizeW-1:0] rem_q, rem_d;

  always_comb begin
    logic [dmoc_pkg::TableSizeW:0] trial;
    num_d = num_q;
    rem_d = rem_q;
    for (int i = 0; i < dmoc_pkg::DigitW; i++) begin
      trial = {rem_d, num_d[dmoc_pkg::HalfW-1]};
      num_d = {num_d[dmoc_pkg::HalfW-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        trial = trial - {1'b0, divisor_i};
      end
      rem_d = trial[dmoc_pkg::TableSizeW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
    end else if (step_i) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign rem_o = rem_q;

endmodule

### design/dmoc_dp.sv
// datapath: config registers, hash fold, entry stores, compare and result register
// depends on dmoc_pkg and dmoc_rem

module dmoc_dp #(
  parameter int unsigned MaxSlots = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [dmoc_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [dmoc_pkg::TableSizeW-1:0]     cfg_data_i,
  input  dmoc_pkg::item_t                     item_i,
  input  dmoc_pkg::cmd_t                      cmd_i,
  output dmoc_pkg::status_t                   status_o,
  output dmoc_pkg::result_t                   result_o,
  output logic                                done_o
);

  localparam int unsigned IdxW = $clog2(MaxSlots);

  logic [dmoc_pkg::TableSizeW-1:0] table_size_q;
  logic                            two_op_q;
  logic [dmoc_pkg::TableSizeW-1:0] eff_size;

  logic [dmoc_pkg::OpW-1:0]     op_q;
  logic [dmoc_pkg::HandleW-1:0] a_q, b_q, val_q;
  logic [dmoc_pkg::SlotW-1:0]   slot_q;

  logic [dmoc_pkg::HandleW-1:0] key;
  logic [dmoc_pkg::HalfW-1:0]   folded;
  logic [dmoc_pkg::TableSizeW-1:0] rem;
  logic [31:0]                  rem_ext, slot_ext;

  logic [IdxW-1:0] clr_addr_q;
  logic [IdxW-1:0] wr_addr, rd_addr;
  logic            wr_main, wr_second, slot_ok;
  logic [dmoc_pkg::HandleW-1:0] wr_a, wr_b, wr_val;

  logic [dmoc_pkg::HandleW-1:0] first_store_q  [MaxSlots];
  logic [dmoc_pkg::HandleW-1:0] second_store_q [MaxSlots];
  logic [dmoc_pkg::HandleW-1:0] result_store_q [MaxSlots];
  logic [dmoc_pkg::HandleW-1:0] rd_first_q, rd_second_q, rd_result_q;
  logic [dmoc_pkg::HandleW-1:0] cmp_second;
  logic                         hit;

  dmoc_pkg::result_t res_q, res_d;
  logic              done_q, done_d;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= dmoc_pkg::TableSizeRst;
      two_op_q     <= dmoc_pkg::TwoOperandRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == dmoc_pkg::CFG_TABLE_SIZE) begin
        table_size_q <= cfg_data_i;
      end else if (cfg_index_i == dmoc_pkg::CFG_TWO_OPERAND) begin
        two_op_q <= cfg_data_i[0];
      end
    end
  end

  // zero acts as one, oversize clamps to the store depth
  always_comb begin
    if (table_size_q == '0) begin
      eff_size = dmoc_pkg::TableSizeW'(1);
    end else if (32'(table_size_q) > 32'(MaxSlots)) begin
      eff_size = dmoc_pkg::TableSizeW'(MaxSlots);
    end else begin
      eff_size = table_size_q;
    end
  end

  // latch the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= item_i.operation;
      a_q    <= item_i.first_operand;
      b_q    <= item_i.second_operand;
      slot_q <= item_i.slot;
      val_q  <= item_i.stored_value;
    end
  end

  // fold of the key, loaded straight into the remainder unit
  assign key = (item_i.operation == dmoc_pkg::OP_LOOKUP2)
             ? item_i.first_operand + item_i.second_operand
             : item_i.first_operand;
  assign folded = key[dmoc_pkg::HalfW-1:0] ^ key[dmoc_pkg::HandleW-1:dmoc_pkg::HalfW];

  dmoc_rem u_rem (
    .clk_i      (clk_i),
    .load_i     (cmd_i.accept),
    .step_i     (cmd_i.div_step),
    .dividend_i (folded),
    .divisor_i  (eff_size),
    .rem_o      (rem)
  );

  assign status_o.key_zero = (item_i.first_operand == '0)
                           || ((item_i.operation == dmoc_pkg::OP_LOOKUP2)
                               && (item_i.second_operand == '0));
  assign status_o.clear_last = (clr_addr_q == IdxW'(MaxSlots - 1));

  // clear sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear_wr) begin
      clr_addr_q <= status_o.clear_last ? '0 : clr_addr_q + 1'b1;
    end
  end

  // write port: clear sweep or insert
  assign rem_ext  = 32'(rem);
  assign slot_ext = 32'(slot_q);
  assign rd_addr  = rem_ext[IdxW-1:0];
  assign slot_ok  = {1'b0, slot_q} < eff_size;

  always_comb begin
    if (cmd_i.clear_wr) begin
      wr_addr   = clr_addr_q;
      wr_main   = 1'b1;
      wr_second = 1'b1;
      wr_a      = '0;
      wr_b      = '0;
      wr_val    = '0;
    end else begin
      wr_addr   = slot_ext[IdxW-1:0];
      wr_main   = cmd_i.emit_insert && slot_ok;
      wr_second = cmd_i.emit_insert && slot_ok && two_op_q
                  && (op_q == dmoc_pkg::OP_INSERT2);
      wr_a      = a_q;
      wr_b      = b_q;
      wr_val    = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_main) begin
      first_store_q[wr_addr] <= wr_a;
    end
    if (cmd_i.mem_read) begin
      rd_first_q <= first_store_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_second) begin
      second_store_q[wr_addr] <= wr_b;
    end
    if (cmd_i.mem_read) begin
      rd_second_q <= second_store_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_main) begin
      result_store_q[wr_addr] <= wr_val;
    end
    if (cmd_i.mem_read) begin
      rd_result_q <= result_store_q[rd_addr];
    end
  end

  // compare; on two-operand lookups, swapped operands also match
  assign cmp_second = two_op_q ? rd_second_q : '0;

  always_comb begin
    if (op_q == dmoc_pkg::OP_LOOKUP2) begin
      hit = ((rd_first_q == a_q) && (cmp_second == b_q))
         || ((rd_first_q == b_q) && (cmp_second == a_q));
    end else begin
      hit = (rd_first_q == a_q);
    end
  end

  always_comb begin
    res_d  = res_q;
    done_d = 1'b0;
    if (cmd_i.emit_lookup) begin
      done_d                = 1'b1;
      res_d.found           = hit;
      res_d.found_value     = hit ? rd_result_q : '0;
      res_d.miss_slot       = hit ? '0 : rem[dmoc_pkg::SlotW-1:0];
      res_d.miss_slot_valid = !hit;
    end else if (cmd_i.emit_insert || cmd_i.emit_zero) begin
      done_d = 1'b1;
      res_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  assign result_o = res_q;
  assign done_o   = done_q;

endmodule

### design/dmoc_ctrl.sv
// controller state machine: sequences hashing, store access, inserts and clear sweeps
// depends on dmoc_pkg

module dmoc_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [dmoc_pkg::OpW-1:0]      operation_i,
  input  dmoc_pkg::status_t             status_i,
  output dmoc_pkg::cmd_t                cmd_o,
  output logic                          busy
);

  dmoc_pkg::state_e            state_q, state_d;
  logic [dmoc_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                         clr_emit_q, clr_emit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dmoc_pkg::ST_CLEAR;
      cnt_q      <= '0;
      clr_emit_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      clr_emit_q <= clr_emit_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    clr_emit_d = clr_emit_q;
    cmd_o      = '0;
    unique case (state_q)
      dmoc_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          cnt_d        = '0;
          priority if ((operation_i == dmoc_pkg::OP_LOOKUP1)
                       || (operation_i == dmoc_pkg::OP_LOOKUP2)) begin
            state_d = status_i.key_zero ? dmoc_pkg::ST_EMPTY : dmoc_pkg::ST_DIV;
          end else if ((operation_i == dmoc_pkg::OP_INSERT1)
                       || (operation_i == dmoc_pkg::OP_INSERT2)) begin
            state_d = dmoc_pkg::ST_INSERT;
          end else if (operation_i == dmoc_pkg::OP_CLEAR) begin
            state_d    = dmoc_pkg::ST_CLEAR;
            clr_emit_d = 1'b1;
          end else begin
            state_d = dmoc_pkg::ST_EMPTY;
          end
        end
      end
      dmoc_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == dmoc_pkg::DivCntW'(dmoc_pkg::DivSteps - 1)) begin
          state_d = dmoc_pkg::ST_READ;
        end
      end
      dmoc_pkg::ST_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = dmoc_pkg::ST_CMP;
      end
      dmoc_pkg::ST_CMP: begin
        cmd_o.emit_lookup = 1'b1;
        state_d           = dmoc_pkg::ST_IDLE;
      end
      dmoc_pkg::ST_INSERT: begin
        cmd_o.emit_insert = 1'b1;
        state_d           = dmoc_pkg::ST_IDLE;
      end
      dmoc_pkg::ST_EMPTY: begin
        cmd_o.emit_zero = 1'b1;
        state_d         = dmoc_pkg::ST_IDLE;
      end
      dmoc_pkg::ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.clear_last) begin
          cmd_o.emit_zero = clr_emit_q;
          clr_emit_d      = 1'b0;
          state_d         = dmoc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dmoc_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != dmoc_pkg::ST_IDLE);

endmodule

### design/direct_mapped_operation_cache_top.sv
// lookup: from start, the remainder steps, a store read and the compare, then done_o
// insert, unknown code, zero-operand lookup: one emit state; clear: MAX_SLOTS entries, an entry a cycle
// the remainder unit retires four bits of the 32-bit fold per cycle; the next word is
// taken in the cycle done_o is high, and done_o cannot be held off by the receiver
// reset: busy stays high while the stores are swept to zero;
// config writes are taken at any time, with table_size 4096 and two operands after reset

module direct_mapped_operation_cache_top #(
  parameter int unsigned MAX_SLOTS = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command channel
  input  logic                             start,
  output logic                             busy,
  input  dmoc_pkg::item_t                  item_i,
  // result word, valid with each done_o pulse
  output logic                             done_o,
  output dmoc_pkg::result_t                result_o,
  // config write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dmoc_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [dmoc_pkg::TableSizeW-1:0]  cfg_data_i
);

  dmoc_pkg::cmd_t    cmd;
  dmoc_pkg::status_t status;
  logic              cfg_we;

  // config registers never stall
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // sequencing: idle, remainder steps, read, compare, or insert, or the empty result, or the clear sweep
  dmoc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (item_i.operation),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  // the three entry stores live here, with the fold, remainder unit and result register
  dmoc_dp #(
    .MaxSlots (MAX_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (result_o),
    .done_o      (done_o)
  );

endmodule
